[hdl/cwt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cwt_pkg;

   localparam int LINE_COUNTER_BITS_DEFAULT = 32;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;

   localparam logic [7:0] COLUMN_LIMIT_RESET = 8'd80;
   localparam logic [7:0] COMMENT_MARK_RESET = 8'h25;
   localparam logic [7:0] JOIN_MARK_RESET    = 8'h3D;

   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COLUMN_LIMIT = 2'd0,
      CSR_COMMENT_MARK = 2'd1,
      CSR_JOIN_MARK    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] column_limit;
      logic [7:0] comment_mark;
      logic [7:0] join_mark;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  out_char;
      logic        starts_token;
      logic [31:0] line_number;
      logic        stream_done;
   } rsp_word_type;

   // slot 0: released carriage return, slot 1: current byte, slot 2: done marker
   typedef struct packed {
      logic [2:0]         valid;
      rsp_word_type [2:0] word;
   } rsp_push_type;

endpackage

`default_nettype wire

[hdl/cwt_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cwt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       is_final_char;

   modport source (output valid, output in_char, output is_final_char, input ready);
   modport sink (input valid, input in_char, input is_final_char, output ready);
endinterface

`default_nettype wire

[hdl/cwt_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cwt_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_char;
   logic        starts_token;
   logic [31:0] line_number;
   logic        stream_done;

   modport source (output valid, output out_char, output starts_token,
                   output line_number, output stream_done, input ready);
   modport sink (input valid, input out_char, input starts_token,
                 input line_number, input stream_done, output ready);
endinterface

`default_nettype wire

[hdl/cwt_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module cwt_core #(
   parameter int LINE_COUNTER_BITS = cwt_pkg::LINE_COUNTER_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            in_char,
   input  logic                  is_final_char,
   input  cwt_pkg::cfg_type      cfg,
   output cwt_pkg::rsp_push_type push
);

   typedef struct packed {
      logic       comment_active;
      logic       word_active;
      logic       word_seen_in_line;
      logic [7:0] last_word_char;
   } line_state_type;

   typedef struct packed {
      line_state_type state;
      logic           emit;
      logic           start;
   } feed_result_type;

   localparam logic [LINE_COUNTER_BITS-1:0] LineOne = LINE_COUNTER_BITS'(1);

   line_state_type               line_state_ff, line_state_in;
   logic [7:0]                   column_count_ff, column_count_in;
   logic                         cr_held_ff, cr_held_in;
   logic [LINE_COUNTER_BITS-1:0] line_count_ff, line_count_in;

   function automatic logic [31:0] to_line32(input logic [LINE_COUNTER_BITS-1:0] v);
      logic [63:0] wide;
      wide = 64'(v);
      if (wide > 64'h0000_0000_FFFF_FFFF) begin
         return 32'hFFFF_FFFF;
      end
      return wide[31:0];
   endfunction

   // one byte within the limit and outside a comment
   function automatic feed_result_type feed(input line_state_type s, input logic [7:0] ch,
                                            input cwt_pkg::cfg_type c);
      feed_result_type r;
      r.state = s;
      r.emit  = 1'b0;
      r.start = 1'b0;
      if (ch == c.comment_mark) begin
         r.state.comment_active = 1'b1;
         r.state.word_active    = 1'b0;
      end else if (ch == cwt_pkg::CHAR_SPACE || ch == cwt_pkg::CHAR_TAB ||
                   ch == cwt_pkg::CHAR_COMMA) begin
         r.state.word_active = 1'b0;
      end else begin
         r.emit = 1'b1;
         if (!s.word_active) begin
            r.start = !(s.word_seen_in_line &&
                        (s.last_word_char == c.join_mark || ch == c.join_mark));
            r.state.word_active       = 1'b1;
            r.state.word_seen_in_line = 1'b1;
         end
         r.state.last_word_char = ch;
      end
      return r;
   endfunction

   feed_result_type cr_feed, char_feed;
   logic [31:0]     line_now;

   always_comb begin
      line_state_in   = line_state_ff;
      column_count_in = column_count_ff;
      cr_held_in      = cr_held_ff;
      line_count_in   = line_count_ff;
      line_now        = to_line32(line_count_ff);
      cr_feed         = '0;
      char_feed       = '0;
      push            = '0;

      if (in_char == cwt_pkg::CHAR_NEWLINE) begin
         line_state_in   = '0;
         column_count_in = '0;
         cr_held_in      = 1'b0;
         if (line_count_ff != '1) begin
            line_count_in = line_count_ff + LineOne;
         end
      end else begin
         if (cr_held_ff) begin
            cr_held_in    = 1'b0;
            cr_feed       = feed(line_state_in, cwt_pkg::CHAR_CR, cfg);
            line_state_in = cr_feed.state;
            push.valid[0] = cr_feed.emit;
         end
         if (column_count_ff < cfg.column_limit) begin
            column_count_in = column_count_ff + 8'd1;
            if (!line_state_in.comment_active) begin
               if (in_char == cwt_pkg::CHAR_CR) begin
                  cr_held_in = 1'b1;
               end else begin
                  char_feed     = feed(line_state_in, in_char, cfg);
                  line_state_in = char_feed.state;
                  push.valid[1] = char_feed.emit;
               end
            end
         end
      end

      push.word[0] = '{out_char: cwt_pkg::CHAR_CR, starts_token: cr_feed.start,
                       line_number: line_now, stream_done: 1'b0};
      push.word[1] = '{out_char: in_char, starts_token: char_feed.start,
                       line_number: line_now, stream_done: 1'b0};
      push.word[2] = '{out_char: 8'd0, starts_token: 1'b0,
                       line_number: to_line32(line_count_in), stream_done: 1'b1};
      push.valid[2] = is_final_char;

      if (is_final_char) begin
         line_state_in   = '0;
         column_count_in = '0;
         cr_held_in      = 1'b0;
         line_count_in   = LineOne;
      end

      if (!accept) begin
         push.valid = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_state_ff   <= '0;
         column_count_ff <= '0;
         cr_held_ff      <= 1'b0;
         line_count_ff   <= LineOne;
      end else if (accept) begin
         line_state_ff   <= line_state_in;
         column_count_ff <= column_count_in;
         cr_held_ff      <= cr_held_in;
         line_count_ff   <= line_count_in;
      end
   end

endmodule

`default_nettype wire

[hdl/cwt_rsp_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module cwt_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  cwt_pkg::rsp_push_type push,
   output logic                  has_room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cwt_pkg::rsp_word_type out_word
);

   localparam int Depth     = 4;
   localparam int IndexBits = $clog2(Depth);

   cwt_pkg::rsp_word_type entry_ff [Depth];
   cwt_pkg::rsp_word_type entry_in [Depth];
   logic [IndexBits-1:0]  head_ff, head_in;
   logic [IndexBits-1:0]  tail_ff, tail_in;
   logic [IndexBits:0]    count_ff, count_in;
   logic [IndexBits-1:0]  slot_addr [3];
   logic [IndexBits:0]    push_count;
   logic                  pop;

   // three free slots take the worst case of one byte
   assign has_room  = count_ff <= (IndexBits+1)'(Depth - 3);
   assign out_valid = count_ff != '0;
   assign out_word  = entry_ff[head_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      slot_addr[0] = tail_ff;
      slot_addr[1] = tail_ff + IndexBits'(push.valid[0]);
      slot_addr[2] = slot_addr[1] + IndexBits'(push.valid[1]);
      push_count   = (IndexBits+1)'(push.valid[0]) + (IndexBits+1)'(push.valid[1]) +
                     (IndexBits+1)'(push.valid[2]);
      for (int i = 0; i < Depth; i++) begin
         entry_in[i] = entry_ff[i];
         for (int s = 0; s < 3; s++) begin
            if (push.valid[s] && slot_addr[s] == IndexBits'(i)) begin
               entry_in[i] = push.word[s];
            end
         end
      end
      tail_in  = tail_ff + IndexBits'(push_count);
      head_in  = head_ff + IndexBits'(pop);
      count_in = count_ff + push_count - (IndexBits+1)'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < Depth; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[hdl/column_limited_word_tokenizer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Tokenizes a text stream one byte per word on req_chan and returns token bytes on
// rsp_chan, each tagged with its line number and a token-start flag; the last byte of
// the stream is followed by a done marker. A byte is taken on a req_chan handshake;
// its words are registered into a four-entry result queue. While rsp_chan.ready is
// high the result port drains one word per clock, so the block runs at one byte per
// clock as long as each byte yields at most one word. A byte can yield up to three
// words (a released carriage return, the byte, the done marker), and req_chan.ready
// drops while the queue has fewer than three free entries. Registers are written
// through the csr_ port and must only change while the block is idle.
module column_limited_word_tokenizer #(
   parameter int LINE_COUNTER_BITS = cwt_pkg::LINE_COUNTER_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   cwt_req_if.sink                            req_chan,
   cwt_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [cwt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [7:0]                         csr_write_data
);

   cwt_pkg::cfg_type      cfg_ff;
   cwt_pkg::rsp_push_type push;
   cwt_pkg::rsp_word_type out_word;
   logic                  has_room;
   logic                  accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.column_limit <= cwt_pkg::COLUMN_LIMIT_RESET;
         cfg_ff.comment_mark <= cwt_pkg::COMMENT_MARK_RESET;
         cfg_ff.join_mark    <= cwt_pkg::JOIN_MARK_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            cwt_pkg::CSR_COLUMN_LIMIT: cfg_ff.column_limit <= csr_write_data;
            cwt_pkg::CSR_COMMENT_MARK: cfg_ff.comment_mark <= csr_write_data;
            cwt_pkg::CSR_JOIN_MARK:    cfg_ff.join_mark    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign req_chan.ready = has_room;
   assign accept         = req_chan.valid && has_room;

   cwt_core #(
      .LINE_COUNTER_BITS(LINE_COUNTER_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_char       (req_chan.in_char),
      .is_final_char (req_chan.is_final_char),
      .cfg           (cfg_ff),
      .push          (push)
   );

   cwt_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_word  (out_word)
   );

   assign rsp_chan.out_char     = out_word.out_char;
   assign rsp_chan.starts_token = out_word.starts_token;
   assign rsp_chan.line_number  = out_word.line_number;
   assign rsp_chan.stream_done  = out_word.stream_done;

endmodule

`default_nettype wire
